[design/obdm_pkg.sv]
`timescale 1ns / 1ps
package obdm_pkg;
	localparam int unsigned LEVELS_DEF      = 64;
	localparam int unsigned PRICE_BITS_DEF  = 32;
	localparam int unsigned AMOUNT_BITS_DEF = 40;
	localparam int unsigned DEPTH_NEAR      = 5;
	localparam int unsigned DEPTH_FAR       = 10;
	localparam int unsigned IMB_FRAC        = 16;
	localparam int unsigned IMB_W           = 18;

	typedef enum logic [1:0] {
		KIND_CLEAR     = 2'd0,
		KIND_UPDATE    = 2'd1,
		KIND_END_GROUP = 2'd2,
		KIND_SAMPLE    = 2'd3
	} kind_t;
endpackage

[design/order_book_depth_metrics.sv]
`timescale 1ns / 1ps
// Price-level book with depth metrics. Clear and end of group are handled in the
// idle state, and a sample that finds the book not valid goes straight to emit.
// A level update walks the sorted table through one table read per step: it
// scans the levels ahead of the price, then moves each following level when a
// level is inserted or removed. A valid sample reads up to 10 levels per side
// and then runs three 17-step divisions on one shared divider. A result waits in
// the output register while the next item is taken.
module order_book_depth_metrics #(
	parameter int unsigned LEVELS      = obdm_pkg::LEVELS_DEF,
	parameter int unsigned PRICE_BITS  = obdm_pkg::PRICE_BITS_DEF,
	parameter int unsigned AMOUNT_BITS = obdm_pkg::AMOUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic               side,
	input  logic [31:0]        price,
	input  logic [39:0]        amount,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               book_ok,
	output logic [31:0]        top_bid,
	output logic [31:0]        top_ask,
	output logic [39:0]        bid_top_qty,
	output logic [39:0]        ask_top_qty,
	output logic [43:0]        bid_depth_five,
	output logic [43:0]        ask_depth_five,
	output logic [43:0]        bid_depth_ten,
	output logic [43:0]        ask_depth_ten,
	output logic signed [17:0] imbalance_one,
	output logic signed [17:0] imbalance_five,
	output logic signed [17:0] imbalance_ten
);
	localparam int unsigned CNT_W  = $clog2(LEVELS + 1);
	localparam int unsigned IDX_W  = $clog2(LEVELS);
	localparam int unsigned ADDR_W = IDX_W + 1;
	localparam int unsigned ENT_W  = PRICE_BITS + AMOUNT_BITS;
	localparam int unsigned SUM_W  = AMOUNT_BITS + 4;
	localparam int unsigned K_W    = $clog2(obdm_pkg::DEPTH_FAR + 1);
	localparam int unsigned IMB_W  = obdm_pkg::IMB_W;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH, S_SCMP, S_MISS, S_INS, S_INS_WR, S_DEL, S_DEL_WR,
		S_DEP, S_DEP_ACC, S_DIV_GO, S_DIV_WAIT, S_EMIT
	} state_t;

	state_t                 state_q;
	logic                   side_q;
	logic [PRICE_BITS-1:0]  price_q;
	logic [AMOUNT_BITS-1:0] amount_q;
	logic [CNT_W-1:0]       pos_q;
	logic [CNT_W-1:0]       idx_q;
	logic [CNT_W-1:0]       bid_used_q;
	logic [CNT_W-1:0]       ask_used_q;
	logic                   ready_q;
	logic                   pending_q;
	logic [PRICE_BITS-1:0]  bid_top_p_q;
	logic [AMOUNT_BITS-1:0] bid_top_a_q;
	logic [PRICE_BITS-1:0]  ask_top_p_q;
	logic [AMOUNT_BITS-1:0] ask_top_a_q;
	logic [K_W-1:0]         k_q;
	logic                   dep_side_q;
	logic [SUM_W-1:0]       b5_q;
	logic [SUM_W-1:0]       b10_q;
	logic [SUM_W-1:0]       a5_q;
	logic [SUM_W-1:0]       a10_q;
	logic                   smp_ok_q;
	logic [1:0]             dsel_q;
	logic [IMB_W-1:0]       imb1_q;
	logic [IMB_W-1:0]       imb5_q;
	logic [IMB_W-1:0]       imb10_q;

	logic                   out_valid_q;
	logic                   book_ok_q;
	logic [31:0]            top_bid_q;
	logic [31:0]            top_ask_q;
	logic [39:0]            bid_top_qty_q;
	logic [39:0]            ask_top_qty_q;
	logic [43:0]            bid_d5_q;
	logic [43:0]            ask_d5_q;
	logic [43:0]            bid_d10_q;
	logic [43:0]            ask_d10_q;
	logic [IMB_W-1:0]       imb_one_q;
	logic [IMB_W-1:0]       imb_five_q;
	logic [IMB_W-1:0]       imb_ten_q;

	logic [ENT_W-1:0]       mem_q [2**ADDR_W];
	logic [ENT_W-1:0]       rd_data_q;

	logic [ADDR_W-1:0]      rd_addr;
	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic [ENT_W-1:0]       wr_data;

	logic [CNT_W-1:0]       n_cur;
	logic [CNT_W-1:0]       dep_n;
	logic [CNT_W-1:0]       idx_m1;
	logic [CNT_W-1:0]       idx_p1;
	logic [PRICE_BITS-1:0]  rd_price;
	logic [AMOUNT_BITS-1:0] rd_amt;
	logic                   ahead;
	logic                   hit_wr;
	logic                   struct_ok;
	logic                   out_load;

	logic                   div_start;
	logic [SUM_W-1:0]       div_b;
	logic [SUM_W-1:0]       div_a;
	logic                   div_done;
	logic signed [IMB_W-1:0] div_quo;

	assign n_cur    = side_q ? bid_used_q : ask_used_q;
	assign dep_n    = dep_side_q ? bid_used_q : ask_used_q;
	assign idx_m1   = idx_q - 1'b1;
	assign idx_p1   = idx_q + 1'b1;
	assign rd_price = rd_data_q[ENT_W-1:AMOUNT_BITS];
	assign rd_amt   = rd_data_q[AMOUNT_BITS-1:0];
	assign ahead    = side_q ? (rd_price > price_q) : (rd_price < price_q);
	assign hit_wr   = (state_q == S_SCMP) && !ahead && (rd_price == price_q)
		&& (amount_q != '0);
	assign struct_ok = (bid_used_q != '0) && (ask_used_q != '0)
		&& (bid_top_p_q != '0) && (ask_top_p_q > bid_top_p_q);
	assign out_load  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign div_start = (state_q == S_DIV_GO);

	always_comb begin
		case (dsel_q)
			2'd0: begin
				div_b = SUM_W'(bid_top_a_q);
				div_a = SUM_W'(ask_top_a_q);
			end
			2'd1: begin
				div_b = b5_q;
				div_a = a5_q;
			end
			default: begin
				div_b = b10_q;
				div_a = a10_q;
			end
		endcase
	end

	always_comb begin
		rd_addr = {side_q, pos_q[IDX_W-1:0]};
		wr_en   = 1'b0;
		wr_addr = {side_q, pos_q[IDX_W-1:0]};
		wr_data = {price_q, amount_q};
		unique case (state_q)
			S_SCMP: wr_en = hit_wr;
			S_INS: begin
				if (idx_q == pos_q) begin
					wr_en = 1'b1;
				end else begin
					rd_addr = {side_q, idx_m1[IDX_W-1:0]};
				end
			end
			S_INS_WR: begin
				wr_en   = 1'b1;
				wr_addr = {side_q, idx_q[IDX_W-1:0]};
				wr_data = rd_data_q;
			end
			S_DEL: rd_addr = {side_q, idx_p1[IDX_W-1:0]};
			S_DEL_WR: begin
				wr_en   = 1'b1;
				wr_addr = {side_q, idx_q[IDX_W-1:0]};
				wr_data = rd_data_q;
			end
			S_DEP: rd_addr = {dep_side_q, IDX_W'(k_q)};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	obdm_div #(
		.SUM_W(SUM_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.b     (div_b),
		.a     (div_a),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			side_q        <= 1'b0;
			price_q       <= '0;
			amount_q      <= '0;
			pos_q         <= '0;
			idx_q         <= '0;
			bid_used_q    <= '0;
			ask_used_q    <= '0;
			ready_q       <= 1'b0;
			pending_q     <= 1'b0;
			bid_top_p_q   <= '0;
			bid_top_a_q   <= '0;
			ask_top_p_q   <= '0;
			ask_top_a_q   <= '0;
			k_q           <= '0;
			dep_side_q    <= 1'b0;
			b5_q          <= '0;
			b10_q         <= '0;
			a5_q          <= '0;
			a10_q         <= '0;
			smp_ok_q      <= 1'b0;
			dsel_q        <= '0;
			imb1_q        <= '0;
			imb5_q        <= '0;
			imb10_q       <= '0;
			out_valid_q   <= 1'b0;
			book_ok_q     <= 1'b0;
			top_bid_q     <= '0;
			top_ask_q     <= '0;
			bid_top_qty_q <= '0;
			ask_top_qty_q <= '0;
			bid_d5_q      <= '0;
			ask_d5_q      <= '0;
			bid_d10_q     <= '0;
			ask_d10_q     <= '0;
			imb_one_q     <= '0;
			imb_five_q    <= '0;
			imb_ten_q     <= '0;
		end else begin
			// cached best level of each side
			if (wr_en && wr_addr[IDX_W-1:0] == '0) begin
				if (wr_addr[IDX_W]) begin
					bid_top_p_q <= wr_data[ENT_W-1:AMOUNT_BITS];
					bid_top_a_q <= wr_data[AMOUNT_BITS-1:0];
				end else begin
					ask_top_p_q <= wr_data[ENT_W-1:AMOUNT_BITS];
					ask_top_a_q <= wr_data[AMOUNT_BITS-1:0];
				end
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						side_q   <= side;
						price_q  <= PRICE_BITS'(price);
						amount_q <= AMOUNT_BITS'(amount);
						unique case (obdm_pkg::kind_t'(kind))
							obdm_pkg::KIND_CLEAR: begin
								bid_used_q <= '0;
								ask_used_q <= '0;
								ready_q    <= 1'b0;
								pending_q  <= 1'b1;
							end
							obdm_pkg::KIND_UPDATE: begin
								pos_q   <= '0;
								state_q <= S_SRCH;
							end
							obdm_pkg::KIND_END_GROUP: begin
								if (pending_q) begin
									ready_q   <= struct_ok;
									pending_q <= 1'b0;
								end else if (ready_q && !struct_ok) begin
									ready_q <= 1'b0;
								end
							end
							obdm_pkg::KIND_SAMPLE: begin
								smp_ok_q   <= ready_q && struct_ok;
								b5_q       <= '0;
								b10_q      <= '0;
								a5_q       <= '0;
								a10_q      <= '0;
								k_q        <= '0;
								dep_side_q <= 1'b1;
								dsel_q     <= '0;
								state_q    <= (ready_q && struct_ok) ? S_DEP : S_EMIT;
							end
							default: ;
						endcase
					end
				end
				S_SRCH: begin
					state_q <= (pos_q == n_cur) ? S_MISS : S_SCMP;
				end
				S_SCMP: begin
					if (ahead) begin
						pos_q   <= pos_q + 1'b1;
						state_q <= S_SRCH;
					end else if (rd_price == price_q) begin
						if (amount_q == '0) begin
							idx_q   <= pos_q;
							state_q <= S_DEL;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					if (amount_q == '0) begin
						state_q <= S_IDLE;
					end else if (n_cur == CNT_W'(LEVELS)) begin
						ready_q   <= 1'b0;
						pending_q <= 1'b0;
						state_q   <= S_IDLE;
					end else begin
						idx_q   <= n_cur;
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (idx_q == pos_q) begin
						if (side_q) begin
							bid_used_q <= bid_used_q + 1'b1;
						end else begin
							ask_used_q <= ask_used_q + 1'b1;
						end
						state_q <= S_IDLE;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					idx_q   <= idx_m1;
					state_q <= S_INS;
				end
				S_DEL: begin
					if (idx_p1 == n_cur) begin
						if (side_q) begin
							bid_used_q <= bid_used_q - 1'b1;
						end else begin
							ask_used_q <= ask_used_q - 1'b1;
						end
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DEL_WR;
					end
				end
				S_DEL_WR: begin
					idx_q   <= idx_p1;
					state_q <= S_DEL;
				end
				S_DEP: begin
					if (k_q == K_W'(obdm_pkg::DEPTH_FAR) || CNT_W'(k_q) == dep_n) begin
						k_q <= '0;
						if (dep_side_q) begin
							dep_side_q <= 1'b0;
						end else begin
							state_q <= S_DIV_GO;
						end
					end else begin
						state_q <= S_DEP_ACC;
					end
				end
				S_DEP_ACC: begin
					if (dep_side_q) begin
						if (k_q < K_W'(obdm_pkg::DEPTH_NEAR)) begin
							b5_q <= b5_q + SUM_W'(rd_amt);
						end
						b10_q <= b10_q + SUM_W'(rd_amt);
					end else begin
						if (k_q < K_W'(obdm_pkg::DEPTH_NEAR)) begin
							a5_q <= a5_q + SUM_W'(rd_amt);
						end
						a10_q <= a10_q + SUM_W'(rd_amt);
					end
					k_q     <= k_q + 1'b1;
					state_q <= S_DEP;
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						case (dsel_q)
							2'd0:    imb1_q  <= div_quo;
							2'd1:    imb5_q  <= div_quo;
							default: imb10_q <= div_quo;
						endcase
						if (dsel_q == 2'd2) begin
							state_q <= S_EMIT;
						end else begin
							dsel_q  <= dsel_q + 1'b1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_EMIT: begin
					if (out_load) begin
						out_valid_q   <= 1'b1;
						book_ok_q     <= smp_ok_q;
						top_bid_q     <= smp_ok_q ? 32'(bid_top_p_q) : '0;
						top_ask_q     <= smp_ok_q ? 32'(ask_top_p_q) : '0;
						bid_top_qty_q <= smp_ok_q ? 40'(bid_top_a_q) : '0;
						ask_top_qty_q <= smp_ok_q ? 40'(ask_top_a_q) : '0;
						bid_d5_q      <= smp_ok_q ? 44'(b5_q) : '0;
						ask_d5_q      <= smp_ok_q ? 44'(a5_q) : '0;
						bid_d10_q     <= smp_ok_q ? 44'(b10_q) : '0;
						ask_d10_q     <= smp_ok_q ? 44'(a10_q) : '0;
						imb_one_q     <= smp_ok_q ? imb1_q : '0;
						imb_five_q    <= smp_ok_q ? imb5_q : '0;
						imb_ten_q     <= smp_ok_q ? imb10_q : '0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign book_ok        = book_ok_q;
	assign top_bid        = top_bid_q;
	assign top_ask        = top_ask_q;
	assign bid_top_qty    = bid_top_qty_q;
	assign ask_top_qty    = ask_top_qty_q;
	assign bid_depth_five = bid_d5_q;
	assign ask_depth_five = ask_d5_q;
	assign bid_depth_ten  = bid_d10_q;
	assign ask_depth_ten  = ask_d10_q;
	assign imbalance_one  = imb_one_q;
	assign imbalance_five = imb_five_q;
	assign imbalance_ten  = imb_ten_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bid_used_q <= CNT_W'(LEVELS) && ask_used_q <= CNT_W'(LEVELS))
		else $error("level count beyond table size");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !book_ok_q) |-> (top_bid_q == '0 && top_ask_q == '0
		&& bid_d10_q == '0 && imb_one_q == '0 && imb_ten_q == '0))
		else $error("invalid sample carries nonzero fields");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV_WAIT)
		else $error("divider result with no waiting sample");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && obdm_pkg::kind_t'(kind) == obdm_pkg::KIND_CLEAR)
		|=> (pending_q && !ready_q && bid_used_q == '0 && ask_used_q == '0))
		else $error("clear transfer did not empty the book");
endmodule

[design/obdm_div.sv]
`timescale 1ns / 1ps
module obdm_div #(
	parameter int unsigned SUM_W = obdm_pkg::AMOUNT_BITS_DEF + 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [SUM_W-1:0]                  b,
	input  logic [SUM_W-1:0]                  a,
	output logic                              done,
	output logic signed [obdm_pkg::IMB_W-1:0] quo
);
	localparam int unsigned T_W   = SUM_W + 1;
	localparam int unsigned R_W   = SUM_W + 2;
	localparam int unsigned C_W   = $clog2(obdm_pkg::IMB_FRAC + 1);
	localparam int unsigned Q_W   = obdm_pkg::IMB_W;

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_ROUND, D_SIGN} dstate_t;

	dstate_t          state_q;
	logic [T_W-1:0]   t_q;
	logic [R_W-1:0]   r_q;
	logic [Q_W-1:0]   q_q;
	logic [C_W-1:0]   cnt_q;
	logic             neg_q;
	logic             done_q;
	logic [Q_W-1:0]   quo_q;

	logic             ge;
	logic [R_W-1:0]   rn;

	assign ge   = r_q >= R_W'(t_q);
	assign rn   = ge ? r_q - R_W'(t_q) : r_q;
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			t_q     <= '0;
			r_q     <= '0;
			q_q     <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			done_q  <= 1'b0;
			quo_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						t_q   <= T_W'(b) + T_W'(a);
						neg_q <= a > b;
						r_q   <= (a > b) ? R_W'(a - b) : R_W'(b - a);
						q_q   <= '0;
						cnt_q <= '0;
						if (b == '0 && a == '0) begin
							neg_q   <= 1'b0;
							state_q <= D_SIGN;
						end else begin
							state_q <= D_RUN;
						end
					end
				end
				D_RUN: begin
					q_q <= {q_q[Q_W-2:0], ge};
					if (cnt_q == C_W'(obdm_pkg::IMB_FRAC)) begin
						r_q     <= rn;
						state_q <= D_ROUND;
					end else begin
						r_q   <= {rn[R_W-2:0], 1'b0};
						cnt_q <= cnt_q + 1'b1;
					end
				end
				D_ROUND: begin
					if ({r_q[R_W-2:0], 1'b0} >= R_W'(t_q)) begin
						q_q <= q_q + 1'b1;
					end
					state_q <= D_SIGN;
				end
				D_SIGN: begin
					quo_q   <= neg_q ? Q_W'(-q_q) : q_q;
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
	localparam int unsigned NLEV = obdm_pkg::LEVELS_DEF;
	localparam longint unsigned CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic        book_ok;
		logic [31:0] top_bid;
		logic [31:0] top_ask;
		logic [39:0] bid_top_qty;
		logic [39:0] ask_top_qty;
		logic [43:0] bid_depth_five;
		logic [43:0] ask_depth_five;
		logic [43:0] bid_depth_ten;
		logic [43:0] ask_depth_ten;
		logic [17:0] imbalance_one;
		logic [17:0] imbalance_five;
		logic [17:0] imbalance_ten;
	} metrics_t;

	class book_scoreboard;
		logic [31:0] bid_px[NLEV];
		logic [39:0] bid_amt[NLEV];
		logic [31:0] ask_px[NLEV];
		logic [39:0] ask_amt[NLEV];
		int unsigned bid_n;
		int unsigned ask_n;
		bit ready;
		bit snap_armed;
		metrics_t pending_metrics[$];
		int unsigned errors;

		function void apply_level(bit is_bid, logic [31:0] px, logic [39:0] amt);
			int unsigned n;
			int unsigned pos;
			bit hit;
			n = is_bid ? bid_n : ask_n;
			pos = 0;
			while (pos < n && (is_bid ? bid_px[pos] > px : ask_px[pos] < px))
				pos++;
			hit = pos < n && (is_bid ? bid_px[pos] == px : ask_px[pos] == px);
			if (amt == 0) begin
				if (!hit)
					return;
				for (int unsigned k = pos; k + 1 < n; k++) begin
					if (is_bid) begin
						bid_px[k] = bid_px[k + 1];
						bid_amt[k] = bid_amt[k + 1];
					end else begin
						ask_px[k] = ask_px[k + 1];
						ask_amt[k] = ask_amt[k + 1];
					end
				end
				if (is_bid) bid_n--; else ask_n--;
				return;
			end
			if (hit) begin
				if (is_bid) bid_amt[pos] = amt; else ask_amt[pos] = amt;
				return;
			end
			if (n >= NLEV) begin
				ready = 0;
				snap_armed = 0;
				return;
			end
			for (int unsigned k = n; k > pos; k--) begin
				if (is_bid) begin
					bid_px[k] = bid_px[k - 1];
					bid_amt[k] = bid_amt[k - 1];
				end else begin
					ask_px[k] = ask_px[k - 1];
					ask_amt[k] = ask_amt[k - 1];
				end
			end
			if (is_bid) begin
				bid_px[pos] = px;
				bid_amt[pos] = amt;
				bid_n++;
			end else begin
				ask_px[pos] = px;
				ask_amt[pos] = amt;
				ask_n++;
			end
		endfunction

		function bit well_formed();
			if (bid_n == 0 || ask_n == 0)
				return 0;
			return bid_px[0] > 0 && ask_px[0] > bid_px[0];
		endfunction

		function logic [17:0] imbalance(logic [43:0] b, logic [43:0] a);
			logic [63:0] t;
			logic [63:0] r;
			logic [63:0] q;
			t = b + a;
			if (t == 0)
				return 0;
			r = (a > b) ? a - b : b - a;
			q = (r << obdm_pkg::IMB_FRAC) / t;
			r = (r << obdm_pkg::IMB_FRAC) % t;
			if (2 * r >= t)
				q++;
			if (a > b)
				q = -q;
			return q[17:0];
		endfunction

		function void note_input(obdm_pkg::kind_t k, bit s, logic [31:0] px,
			logic [39:0] amt);
			metrics_t m;
			logic [43:0] b5, b10, a5, a10;
			case (k)
				obdm_pkg::KIND_CLEAR: begin
					bid_n = 0;
					ask_n = 0;
					ready = 0;
					snap_armed = 1;
				end
				obdm_pkg::KIND_UPDATE: begin
					apply_level(s, px, amt);
				end
				obdm_pkg::KIND_END_GROUP: begin
					if (snap_armed) begin
						ready = well_formed();
						snap_armed = 0;
					end else if (ready && !well_formed()) begin
						ready = 0;
					end
				end
				default: begin
					m = '0;
					if (ready && well_formed()) begin
						b5 = 0; b10 = 0; a5 = 0; a10 = 0;
						for (int unsigned k2 = 0; k2 < obdm_pkg::DEPTH_FAR; k2++) begin
							if (k2 < bid_n) begin
								if (k2 < obdm_pkg::DEPTH_NEAR) b5 += bid_amt[k2];
								b10 += bid_amt[k2];
							end
							if (k2 < ask_n) begin
								if (k2 < obdm_pkg::DEPTH_NEAR) a5 += ask_amt[k2];
								a10 += ask_amt[k2];
							end
						end
						m.book_ok = 1;
						m.top_bid = bid_px[0];
						m.top_ask = ask_px[0];
						m.bid_top_qty = bid_amt[0];
						m.ask_top_qty = ask_amt[0];
						m.bid_depth_five = b5;
						m.ask_depth_five = a5;
						m.bid_depth_ten = b10;
						m.ask_depth_ten = a10;
						m.imbalance_one = imbalance(bid_amt[0], ask_amt[0]);
						m.imbalance_five = imbalance(b5, a5);
						m.imbalance_ten = imbalance(b10, a10);
					end
					pending_metrics = {pending_metrics, m};
				end
			endcase
		endfunction

		function void check_result(metrics_t got);
			metrics_t want;
			if (pending_metrics.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending_metrics.pop_front();
			if (want.book_ok != got.book_ok) report("book_ok", want.book_ok, got.book_ok);
			if (want.top_bid != got.top_bid) report("top_bid", want.top_bid, got.top_bid);
			if (want.top_ask != got.top_ask) report("top_ask", want.top_ask, got.top_ask);
			if (want.bid_top_qty != got.bid_top_qty) report("bid_top_qty", want.bid_top_qty, got.bid_top_qty);
			if (want.ask_top_qty != got.ask_top_qty) report("ask_top_qty", want.ask_top_qty, got.ask_top_qty);
			if (want.bid_depth_five != got.bid_depth_five)
				report("bid_depth_five", want.bid_depth_five, got.bid_depth_five);
			if (want.ask_depth_five != got.ask_depth_five)
				report("ask_depth_five", want.ask_depth_five, got.ask_depth_five);
			if (want.bid_depth_ten != got.bid_depth_ten)
				report("bid_depth_ten", want.bid_depth_ten, got.bid_depth_ten);
			if (want.ask_depth_ten != got.ask_depth_ten)
				report("ask_depth_ten", want.ask_depth_ten, got.ask_depth_ten);
			if (want.imbalance_one != got.imbalance_one)
				report("imbalance_one", want.imbalance_one, got.imbalance_one);
			if (want.imbalance_five != got.imbalance_five)
				report("imbalance_five", want.imbalance_five, got.imbalance_five);
			if (want.imbalance_ten != got.imbalance_ten)
				report("imbalance_ten", want.imbalance_ten, got.imbalance_ten);
		endfunction

		function void report(string field, logic [63:0] want, logic [63:0] got);
			$display("%0t: %s expected %h actual %h", $time, field, want, got);
			errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] kind = '0;
	logic side = 0;
	logic [31:0] price = '0;
	logic [39:0] amount = '0;
	logic out_valid;
	logic out_stall = 0;
	metrics_t res;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit hold_off = 0;
	longint unsigned cycle_count = 0;
	book_scoreboard book;

	order_book_depth_metrics dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .side(side), .price(price), .amount(amount),
		.out_valid(out_valid), .out_stall(out_stall),
		.book_ok(res.book_ok), .top_bid(res.top_bid), .top_ask(res.top_ask),
		.bid_top_qty(res.bid_top_qty), .ask_top_qty(res.ask_top_qty),
		.bid_depth_five(res.bid_depth_five), .ask_depth_five(res.ask_depth_five),
		.bid_depth_ten(res.bid_depth_ten), .ask_depth_ten(res.ask_depth_ten),
		.imbalance_one(res.imbalance_one), .imbalance_five(res.imbalance_five),
		.imbalance_ten(res.imbalance_ten)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver side: random stall, long hold-off on request
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_result(res);
		out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send(obdm_pkg::kind_t k, bit s, logic [31:0] px, logic [39:0] amt);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		side <= s;
		price <= px;
		amount <= amt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		book.note_input(k, s, px, amt);
	endtask

	function automatic logic [39:0] rand_amount();
		case ($urandom_range(3))
			0: return 40'({$urandom, $urandom});
			1: return 40'hFF_FFFF_FFFF - $urandom_range(3);
			default: return $urandom_range(1000, 1);
		endcase
	endfunction

	// fresh snapshot of a few levels around a mid price, then updates and samples
	task automatic snapshot_group(int unsigned nlev, int unsigned nupd);
		logic [31:0] mid;
		logic [31:0] px;
		bit s;
		mid = $urandom_range(2000, 200);
		if ($urandom_range(9) == 0) mid = 32'hFFFF_FF00;
		send(obdm_pkg::KIND_CLEAR, 0, $urandom, 40'({$urandom, $urandom}));
		for (int unsigned i = 0; i < nlev; i++) begin
			s = 1'($urandom_range(1));
			px = s ? mid - $urandom_range(40, 1) : mid + $urandom_range(40, 0);
			send(obdm_pkg::KIND_UPDATE, s, px, rand_amount());
		end
		send(obdm_pkg::KIND_END_GROUP, 1'($urandom), $urandom, 40'({$urandom, $urandom}));
		for (int unsigned i = 0; i < nupd; i++) begin
			case ($urandom_range(19))
				0: send(obdm_pkg::KIND_SAMPLE, 1'($urandom), $urandom,
					40'({$urandom, $urandom}));
				1: send(obdm_pkg::KIND_END_GROUP, 1'($urandom), $urandom,
					40'({$urandom, $urandom}));
				2: send(obdm_pkg::KIND_UPDATE, 1'($urandom), $urandom,
					40'({$urandom, $urandom}));
				default: begin
					s = 1'($urandom_range(1));
					px = s ? mid - $urandom_range(40, 0) : mid + $urandom_range(40, 0);
					send(obdm_pkg::KIND_UPDATE, s, px,
						($urandom_range(3) == 0) ? 40'd0 : rand_amount());
				end
			endcase
		end
		send(obdm_pkg::KIND_SAMPLE, 1'($urandom), $urandom, 40'({$urandom, $urandom}));
	endtask

	task automatic drain();
		in_valid <= 0;
		while (book.pending_metrics.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		book = new();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty book, extremes, zero price, crossed book, overflow
		send(obdm_pkg::KIND_SAMPLE, 0, 0, 0);
		send(obdm_pkg::KIND_END_GROUP, 0, 0, 0);
		send(obdm_pkg::KIND_CLEAR, 1, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
		send(obdm_pkg::KIND_UPDATE, 1, 32'd0, 40'd5);
		send(obdm_pkg::KIND_UPDATE, 0, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
		send(obdm_pkg::KIND_END_GROUP, 0, 0, 0);
		send(obdm_pkg::KIND_SAMPLE, 0, 0, 0);
		send(obdm_pkg::KIND_UPDATE, 1, 32'd0, 40'd0);
		send(obdm_pkg::KIND_UPDATE, 1, 32'd0, 40'd0);
		send(obdm_pkg::KIND_UPDATE, 1, 32'hFFFF_FFFE, 40'hFF_FFFF_FFFF);
		send(obdm_pkg::KIND_SAMPLE, 0, 0, 0);
		send(obdm_pkg::KIND_CLEAR, 0, 0, 0);
		send(obdm_pkg::KIND_UPDATE, 1, 32'd100, 40'd1);
		send(obdm_pkg::KIND_UPDATE, 0, 32'd101, 40'd3);
		send(obdm_pkg::KIND_END_GROUP, 0, 0, 0);
		send(obdm_pkg::KIND_SAMPLE, 0, 0, 0);
		send(obdm_pkg::KIND_UPDATE, 0, 32'd100, 40'd7);
		send(obdm_pkg::KIND_UPDATE, 0, 32'd101, 40'd0);
		send(obdm_pkg::KIND_END_GROUP, 1, 0, 0);
		send(obdm_pkg::KIND_SAMPLE, 1, 0, 0);
		// fill the bid side past capacity
		send(obdm_pkg::KIND_CLEAR, 0, 0, 0);
		send(obdm_pkg::KIND_UPDATE, 0, 32'd5000, 40'd9);
		for (int unsigned i = 0; i <= NLEV; i++)
			send(obdm_pkg::KIND_UPDATE, 1, 32'd1000 + i, 40'd1 + i);
		send(obdm_pkg::KIND_END_GROUP, 0, 0, 0);
		send(obdm_pkg::KIND_SAMPLE, 0, 0, 0);
		send(obdm_pkg::KIND_UPDATE, 1, 32'd1000, 40'd0);
		send(obdm_pkg::KIND_END_GROUP, 0, 0, 0);
		send(obdm_pkg::KIND_SAMPLE, 0, 0, 0);
		drain();

		// long receiver hold-off while the sender keeps offering items
		fork
			begin
				hold_off <= 1;
				repeat (3000) @(posedge clk);
				hold_off <= 0;
			end
			begin
				for (int unsigned g = 0; g < 4; g++)
					snapshot_group(12, 10);
				in_valid <= 0;
			end
		join

		for (int unsigned ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 58; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 58; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			for (int unsigned g = 0; g < 7; g++)
				snapshot_group($urandom_range(20, 4), $urandom_range(40, 10));
			// a deep book in the last phase
			if (ph == 3)
				snapshot_group(70, 20);
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
		drain();

		if (book.errors == 0 && book.pending_metrics.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
